[src/bcpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bcpa_pkg;

  localparam int NUM_PAGES = 1024;
  localparam int PAGE_W    = 10;
  localparam int CNT_W     = 11;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int WADDR_W   = PAGE_W - BIT_W;
  localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int DBL_STEPS = BIT_W + 1;
  localparam int STAT_W    = 3;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 16;
  localparam int QUEUE_D   = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_RUN      = 3'd1,
    ST_BAD_ARGS    = 3'd2,
    ST_FIRST_FREE  = 3'd3,
    ST_PARTLY_FREE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_REJECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              count_bad;
    logic [CNT_W-1:0]  count;
    logic [PAGE_W-1:0] first;
  } cmd_t;

endpackage

`default_nettype wire

[src/bcpa_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bcpa_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       op_i,
  input  wire logic [bcpa_pkg::CNT_W-1:0]  page_count_i,
  input  wire logic [bcpa_pkg::PAGE_W-1:0] first_page_i,
  output logic                            cmd_valid_o,
  output bcpa_pkg::cmd_t                  cmd_o,
  input  wire logic                       cmd_pop_i
);

  bcpa_pkg::cmd_t cmd_in;
  bcpa_pkg::cmd_t queue_q [bcpa_pkg::QUEUE_D];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;
  logic           alloc_bad, first_bad;
  logic [bcpa_pkg::CNT_W:0] span_end;

  // classify the request
  always_comb begin
    alloc_bad = (page_count_i == '0) ||
                (page_count_i > bcpa_pkg::CNT_W'(bcpa_pkg::NUM_PAGES));
    first_bad = bcpa_pkg::CNT_W'(first_page_i) >= bcpa_pkg::CNT_W'(bcpa_pkg::NUM_PAGES);
    span_end  = {1'b0, bcpa_pkg::CNT_W'(first_page_i)} + {1'b0, page_count_i};
    cmd_in.count     = page_count_i;
    cmd_in.first     = first_page_i;
    cmd_in.count_bad = (page_count_i == '0) ||
                       (span_end > (bcpa_pkg::CNT_W + 1)'(bcpa_pkg::NUM_PAGES));
    if (op_i == bcpa_pkg::OP_ALLOC) begin
      cmd_in.kind = alloc_bad ? bcpa_pkg::CMD_REJECT : bcpa_pkg::CMD_ALLOC;
    end else begin
      cmd_in.kind = first_bad ? bcpa_pkg::CMD_REJECT : bcpa_pkg::CMD_FREE;
    end
  end

  assign in_ready_o  = (cnt_q != 2'(bcpa_pkg::QUEUE_D));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[src/bcpa_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bcpa_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  wire bcpa_pkg::cmd_t              cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output bcpa_pkg::status_e                status_o,
  output logic [bcpa_pkg::PAGE_W-1:0]       start_page_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SET_RD,
    S_SET_WR,
    S_HEAD_RD,
    S_HEAD_EV,
    S_CHK_RD,
    S_CHK_EV,
    S_CLR_RD,
    S_CLR_WR,
    S_OUT
  } state_e;

  state_e                            state_q;
  bcpa_pkg::cmd_t                    cmd_q;
  logic [bcpa_pkg::WADDR_W-1:0]      widx_q;
  logic [bcpa_pkg::CNT_W-1:0]        run_q;
  logic [bcpa_pkg::PAGE_W-1:0]       lo_q, hi_q;
  bcpa_pkg::status_e                 status_q;
  logic [bcpa_pkg::PAGE_W-1:0]       start_q;
  logic [bcpa_pkg::NUM_WORDS-1:0]    wvalid_q;

  logic [bcpa_pkg::WORD_W-1:0]       mem_q [bcpa_pkg::NUM_WORDS];
  logic [bcpa_pkg::WORD_W-1:0]       rd_data_q;
  logic                              rd_valid_q;

  logic [bcpa_pkg::WORD_W-1:0]       word_eff, used, freeb, range_mask, acc, mem_wdata;
  logic [bcpa_pkg::BIT_W:0]          tz, lz;
  logic [bcpa_pkg::BIT_W-1:0]        fit_idx;
  logic                              fit_hit, span_hit, last_word, hi_word, mem_we;
  logic [bcpa_pkg::CNT_W:0]          run_sum;
  logic [bcpa_pkg::CNT_W-1:0]        base, run_next, hi_calc;
  logic [bcpa_pkg::PAGE_W-1:0]       found_start;

  always_comb begin
    logic [bcpa_pkg::WORD_W-1:0] g [bcpa_pkg::DBL_STEPS];
    logic [bcpa_pkg::BIT_W+1:0]  sh;
    logic [bcpa_pkg::PAGE_W-1:0] p;
    word_eff = rd_valid_q ? rd_data_q : '0;
    for (int b = 0; b < bcpa_pkg::WORD_W; b++) begin
      used[b] = word_eff[b] ||
                (bcpa_pkg::CNT_W'({widx_q, bcpa_pkg::BIT_W'(b)}) >=
                 bcpa_pkg::CNT_W'(bcpa_pkg::NUM_PAGES));
      p = {widx_q, bcpa_pkg::BIT_W'(b)};
      range_mask[b] = (p >= lo_q) && (p <= hi_q);
    end
    freeb = ~used;

    // free pages at the low end and at the high end of the word
    tz = (bcpa_pkg::BIT_W + 1)'(bcpa_pkg::WORD_W);
    for (int b = bcpa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (used[b]) begin
        tz = (bcpa_pkg::BIT_W + 1)'(b);
      end
    end
    lz = (bcpa_pkg::BIT_W + 1)'(bcpa_pkg::WORD_W);
    for (int b = 0; b < bcpa_pkg::WORD_W; b++) begin
      if (used[b]) begin
        lz = (bcpa_pkg::BIT_W + 1)'(bcpa_pkg::WORD_W - 1 - b);
      end
    end

    // free runs inside the word, built by doubling
    g[0] = freeb;
    for (int k = 1; k < bcpa_pkg::DBL_STEPS; k++) begin
      g[k] = g[k-1] & (g[k-1] >> (1 << (k - 1)));
    end
    acc = '1;
    sh  = '0;
    for (int i = 0; i < bcpa_pkg::DBL_STEPS; i++) begin
      if (cmd_q.count[i]) begin
        acc = acc & (g[i] >> sh);
        sh  = sh + (bcpa_pkg::BIT_W + 2)'(1 << i);
      end
    end
    fit_idx = '0;
    for (int b = bcpa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (acc[b]) begin
        fit_idx = bcpa_pkg::BIT_W'(b);
      end
    end
    fit_hit = (cmd_q.count <= bcpa_pkg::CNT_W'(bcpa_pkg::WORD_W)) && (acc != '0);

    run_sum  = {1'b0, run_q} + (bcpa_pkg::CNT_W + 1)'(tz);
    span_hit = run_sum >= {1'b0, cmd_q.count};
    base     = bcpa_pkg::CNT_W'({widx_q, bcpa_pkg::BIT_W'(0)});
    run_next = (used == '0) ? run_sum[bcpa_pkg::CNT_W-1:0] : bcpa_pkg::CNT_W'(lz);
    if (span_hit) begin
      found_start = bcpa_pkg::PAGE_W'(base - run_q);
    end else begin
      found_start = {widx_q, fit_idx};
    end
    hi_calc   = bcpa_pkg::CNT_W'(found_start) + cmd_q.count - bcpa_pkg::CNT_W'(1);
    last_word = (widx_q == bcpa_pkg::WADDR_W'(bcpa_pkg::NUM_WORDS - 1));
    hi_word   = (widx_q == hi_q[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_W]);
  end

  assign mem_we    = (state_q == S_SET_WR) || (state_q == S_CLR_WR);
  assign mem_wdata = (state_q == S_SET_WR) ? (word_eff | range_mask)
                                           : (word_eff & ~range_mask);

  assign cmd_pop_o    = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o  = (state_q == S_OUT);
  assign status_o     = status_q;
  assign start_page_o = start_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[widx_q] <= mem_wdata;
    end
    rd_data_q <= mem_q[widx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wvalid_q   <= '0;
      rd_valid_q <= 1'b0;
      widx_q     <= '0;
      run_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      status_q   <= bcpa_pkg::ST_OK;
      start_q    <= '0;
      cmd_q      <= '0;
    end else begin
      rd_valid_q <= wvalid_q[widx_q];
      if (mem_we) begin
        wvalid_q[widx_q] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            start_q <= '0;
            run_q   <= '0;
            unique case (cmd_i.kind)
              bcpa_pkg::CMD_ALLOC: begin
                widx_q  <= '0;
                state_q <= S_SCAN_RD;
              end
              bcpa_pkg::CMD_FREE: begin
                widx_q  <= cmd_i.first[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_W];
                state_q <= S_HEAD_RD;
              end
              default: begin
                status_q <= bcpa_pkg::ST_BAD_ARGS;
                state_q  <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (span_hit || fit_hit) begin
            lo_q     <= found_start;
            hi_q     <= bcpa_pkg::PAGE_W'(hi_calc);
            start_q  <= found_start;
            widx_q   <= found_start[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_W];
            state_q  <= S_SET_RD;
          end else if (last_word) begin
            status_q <= bcpa_pkg::ST_NO_RUN;
            state_q  <= S_OUT;
          end else begin
            run_q   <= run_next;
            widx_q  <= widx_q + bcpa_pkg::WADDR_W'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_SET_RD: state_q <= S_SET_WR;
        S_SET_WR: begin
          if (hi_word) begin
            status_q <= bcpa_pkg::ST_OK;
            state_q  <= S_OUT;
          end else begin
            widx_q  <= widx_q + bcpa_pkg::WADDR_W'(1);
            state_q <= S_SET_RD;
          end
        end
        S_HEAD_RD: state_q <= S_HEAD_EV;
        S_HEAD_EV: begin
          if (!word_eff[cmd_q.first[bcpa_pkg::BIT_W-1:0]]) begin
            status_q <= bcpa_pkg::ST_FIRST_FREE;
            state_q  <= S_OUT;
          end else if (cmd_q.count_bad) begin
            status_q <= bcpa_pkg::ST_BAD_ARGS;
            state_q  <= S_OUT;
          end else begin
            lo_q    <= cmd_q.first;
            hi_q    <= bcpa_pkg::PAGE_W'(bcpa_pkg::CNT_W'(cmd_q.first) + cmd_q.count
                                         - bcpa_pkg::CNT_W'(1));
            state_q <= S_CHK_RD;
          end
        end
        S_CHK_RD: state_q <= S_CHK_EV;
        S_CHK_EV: begin
          if ((word_eff & range_mask) != range_mask) begin
            status_q <= bcpa_pkg::ST_PARTLY_FREE;
            state_q  <= S_OUT;
          end else if (hi_word) begin
            widx_q  <= lo_q[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_W];
            state_q <= S_CLR_RD;
          end else begin
            widx_q  <= widx_q + bcpa_pkg::WADDR_W'(1);
            state_q <= S_CHK_RD;
          end
        end
        S_CLR_RD: state_q <= S_CLR_WR;
        S_CLR_WR: begin
          if (hi_word) begin
            status_q <= bcpa_pkg::ST_OK;
            state_q  <= S_OUT;
          end else begin
            widx_q  <= widx_q + bcpa_pkg::WADDR_W'(1);
            state_q <= S_CLR_RD;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_q != bcpa_pkg::ST_OK || cmd_q.kind != bcpa_pkg::CMD_ALLOC))
      |-> (start_q == '0))
    else $error("start page not zero on a non-allocation result");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (widx_q >= lo_q[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_W]) &&
               (widx_q <= hi_q[bcpa_pkg::PAGE_W-1:bcpa_pkg::BIT_W]))
    else $error("bitmap write outside the run");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !cmd_valid_i) |=> (state_q == S_IDLE))
    else $error("engine left idle without a command");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_EV) |-> (run_q < cmd_q.count))
    else $error("free run carried past the request length");

endmodule

`default_nettype wire

[src/bitmap_contiguous_page_allocator_top.sv]
// channel   dir  tdata (lsb first)                      tuser
// s_axis    in   page_count[10:0], first_page[20:11]    op (0 alloc, 1 free)
// m_axis    out  status[2:0], start_page[12:3]          -
//
// rejected requests go from idle straight to the result state, then one result transaction
// allocate: scan 32-page words (up to 32), read/evaluate; mark words, read/write
// free: read the first page's word, then read/check each word, then read/write to clear
// steps follow the single-port bitmap memory, one word read or written per cycle
// reset clears the bitmap at once through per-word valid flags, no sweep
// a two-entry queue keeps taking requests until full while a result waits on m_axis
`timescale 1ns / 1ps
`default_nettype none

module bitmap_contiguous_page_allocator_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [bcpa_pkg::IN_W-1:0]  s_axis_tdata,  // page_count, first_page
  input  wire logic                      s_axis_tuser,  // op
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [bcpa_pkg::OUT_W-1:0]      m_axis_tdata   // status, start_page
);

  logic                          cmd_valid, cmd_pop;
  bcpa_pkg::cmd_t                cmd;
  bcpa_pkg::status_e             status;
  logic [bcpa_pkg::PAGE_W-1:0]   start_page;

  bcpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .page_count_i (s_axis_tdata[bcpa_pkg::CNT_W-1:0]),
    .first_page_i (s_axis_tdata[bcpa_pkg::CNT_W+bcpa_pkg::PAGE_W-1:bcpa_pkg::CNT_W]),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  bcpa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (status),
    .start_page_o (start_page)
  );

  assign m_axis_tdata = {{(bcpa_pkg::OUT_W - bcpa_pkg::PAGE_W - bcpa_pkg::STAT_W){1'b0}},
                         start_page, status};

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic                        op;
    logic [bcpa_pkg::CNT_W-1:0]  cnt;
    logic [bcpa_pkg::PAGE_W-1:0] first;
    bit                          drain;
  } page_req_t;

  typedef struct packed {
    bcpa_pkg::status_e           status;
    logic [bcpa_pkg::PAGE_W-1:0] start_page;
  } page_result_t;

  typedef struct {
    int base;
    int len;
  } page_run_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [bcpa_pkg::IN_W-1:0]      s_axis_tdata;   // page_count[10:0], first_page[20:11], zero pad
  logic                           s_axis_tuser;   // op
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [bcpa_pkg::OUT_W-1:0]     m_axis_tdata;   // status[2:0], start_page[12:3], zero pad

  page_req_t                      req_q[$];
  page_result_t                   pending_results[$];
  page_run_t                      live_runs[$];
  logic [bcpa_pkg::NUM_PAGES-1:0] shadow_map;
  logic [bcpa_pkg::NUM_PAGES-1:0] page_map;
  page_req_t                      cur_req;
  int                             n_accepted;
  int                             n_mismatch;
  int                             burst_left;
  int                             gap_left;
  int                             hold_left;
  bit                             hold_done;
  logic [5:0]                     mode_cnt;
  logic [1:0]                     ready_mode;

  bitmap_contiguous_page_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // first fit allocate / checked free on a page bitmap
  function automatic void apply_page_req(inout logic [bcpa_pkg::NUM_PAGES-1:0] map,
                                         input logic op,
                                         input logic [bcpa_pkg::CNT_W-1:0] cnt,
                                         input logic [bcpa_pkg::PAGE_W-1:0] first,
                                         output page_result_t res);
    int run;
    int p;
    int s;
    int f;
    int c;
    res.status = bcpa_pkg::ST_OK;
    res.start_page = '0;
    f = first;
    c = cnt;
    if (op == bcpa_pkg::OP_ALLOC) begin
      if (c == 0 || c > bcpa_pkg::NUM_PAGES) begin
        res.status = bcpa_pkg::ST_BAD_ARGS;
      end else begin
        run = 0;
        s = -1;
        for (p = 0; p < bcpa_pkg::NUM_PAGES && s < 0; p++) begin
          if (map[p]) begin
            run = 0;
          end else begin
            run++;
            if (run == c) s = p + 1 - c;
          end
        end
        if (s < 0) begin
          res.status = bcpa_pkg::ST_NO_RUN;
        end else begin
          for (p = s; p < s + c; p++) map[p] = 1'b1;
          res.start_page = s[bcpa_pkg::PAGE_W-1:0];
        end
      end
    end else if (f >= bcpa_pkg::NUM_PAGES) begin
      res.status = bcpa_pkg::ST_BAD_ARGS;
    end else if (!map[f]) begin
      res.status = bcpa_pkg::ST_FIRST_FREE;
    end else if (c == 0 || f + c > bcpa_pkg::NUM_PAGES) begin
      res.status = bcpa_pkg::ST_BAD_ARGS;
    end else begin
      for (p = f; p < f + c; p++) if (!map[p]) res.status = bcpa_pkg::ST_PARTLY_FREE;
      if (res.status == bcpa_pkg::ST_OK) for (p = f; p < f + c; p++) map[p] = 1'b0;
    end
  endfunction

  task automatic queue_req(input logic op, input int cnt, input int first,
                           input bit drain, output page_result_t res);
    page_req_t r;
    r.op = op;
    r.cnt = cnt[bcpa_pkg::CNT_W-1:0];
    r.first = first[bcpa_pkg::PAGE_W-1:0];
    r.drain = drain;
    apply_page_req(shadow_map, r.op, r.cnt, r.first, res);
    if (op == bcpa_pkg::OP_ALLOC && res.status == bcpa_pkg::ST_OK)
      live_runs.push_back('{res.start_page, cnt});
    req_q.push_back(r);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    page_result_t res;
    page_req_t    nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      n_accepted    <= 0;
      burst_left    <= 8;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_page_req(page_map, cur_req.op, cur_req.cnt, cur_req.first, res);
        pending_results.push_back(res);
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() == 0 ||
                     (req_q[0].drain && pending_results.size() != 0)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = req_q.pop_front();
          cur_req <= nxt;
          s_axis_tdata <= {{(bcpa_pkg::IN_W-bcpa_pkg::CNT_W-bcpa_pkg::PAGE_W){1'b0}},
                           nxt.first, nxt.cnt};
          s_axis_tuser <= nxt.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 :
                        ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= 150) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin : rx
    logic pat;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      mode_cnt      <= '0;
      ready_mode    <= '0;
    end else begin
      mode_cnt <= mode_cnt + 6'd1;
      if (mode_cnt == 6'd63) ready_mode <= 2'($urandom_range(0, 3));
      case (ready_mode)
        2'd0: pat = 1'b1;
        2'd1: pat = ($urandom_range(0, 1) == 1);
        2'd2: pat = ($urandom_range(0, 3) == 0);
        default: pat = (mode_cnt[2:0] != 3'd0);
      endcase
      m_axis_tready <= pat && (hold_left == 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    page_result_t                exp_res;
    logic [bcpa_pkg::STAT_W-1:0] act_status;
    logic [bcpa_pkg::PAGE_W-1:0] act_start;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_status = m_axis_tdata[bcpa_pkg::STAT_W-1:0];
      act_start  = m_axis_tdata[bcpa_pkg::STAT_W+bcpa_pkg::PAGE_W-1:bcpa_pkg::STAT_W];
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected transaction: status %0d start_page %0d",
                   act_status, act_start);
      end else begin
        exp_res = pending_results.pop_front();
        if (act_status != exp_res.status || act_start != exp_res.start_page) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: status exp %0d act %0d, start_page exp %0d act %0d",
                     exp_res.status, act_status, exp_res.start_page, act_start);
        end
      end
    end
  end

  initial begin : stim
    page_result_t res;
    page_run_t    run;
    int           r;
    int           idx;
    int           k;
    int           cnt;
    shadow_map = '0;
    page_map   = '0;
    n_mismatch = 0;

    // directed
    queue_req(bcpa_pkg::OP_ALLOC, 0, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 1025, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 2047, 1023, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 1, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 1, 1023, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 1024, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 1, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 2, 1023, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 0, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 4, 1020, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 4, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 5, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 1024, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 1, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 1, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 1, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 1, 1, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 3, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 2, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_ALLOC, 1, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 1025, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 5, 0, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 1, 682, 1'b0, res);
    queue_req(bcpa_pkg::OP_FREE, 1366, 341, 1'b0, res);
    live_runs.delete();

    // random
    for (int i = 0; i < 450; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 85 && live_runs.size() == 0)) begin
        k = $urandom_range(0, 99);
        cnt = (k < 80) ? $urandom_range(1, 16) :
              (k < 92) ? $urandom_range(17, 300) :
              (k < 96) ? $urandom_range(301, 1024) :
              (k < 98) ? 0 : $urandom_range(1025, 2047);
        queue_req(bcpa_pkg::OP_ALLOC, cnt, $urandom_range(0, 1023), i == 0 || i == 300, res);
      end else if (r < 85) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        k = $urandom_range(0, 19);
        cnt = (k < 15) ? run.len :
              (k < 18) ? $urandom_range(1, run.len) : run.len + $urandom_range(1, 4);
        queue_req(bcpa_pkg::OP_FREE, cnt, run.base, i == 0 || i == 300, res);
        if (res.status == bcpa_pkg::ST_OK) begin
          if (cnt >= run.len) live_runs.delete(idx);
          else live_runs[idx] = '{run.base + cnt, run.len - cnt};
        end
      end else begin
        cnt = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 8);
        queue_req(bcpa_pkg::OP_FREE, cnt, $urandom_range(0, 1023), i == 0 || i == 300, res);
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (300) @(posedge clk_i);

    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
src/bcpa_pkg.sv
src/bcpa_front.sv
src/bcpa_back.sv
src/bitmap_contiguous_page_allocator_top.sv
test/tb_top.sv
